FILE: hdl/register_bytecode_executor_assert.svh
// Assertion macros for the register bytecode executor.
// Expects clk and arst_n in the scope of use.
`ifndef REGISTER_BYTECODE_EXECUTOR_ASSERT_SVH
`define REGISTER_BYTECODE_EXECUTOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RBE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define RBE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/rbe_pkg.sv
// Package for the register bytecode executor: opcodes, field widths, defaults.
// No dependencies.
`timescale 1ns / 1ps

package rbe_pkg;

	localparam int NUM_REGS_DEF = 256;
	localparam int PC_WIDTH_DEF = 16;

	localparam int FUNC_W    = 4;
	localparam int REG_IDX_W = 8;
	localparam int WORD_W    = 32;
	localparam int NPC_W     = 16;

	localparam int S_TDATA_W = 64; // 60 bits of fields, padded to bytes
	localparam int M_TDATA_W = 48;
	localparam int M_TUSER_W = 2;

	typedef enum logic [FUNC_W-1:0] {
		OP_RET   = 4'd0,
		OP_ADD   = 4'd1,
		OP_SUB   = 4'd2,
		OP_MUL   = 4'd3,
		OP_DIV   = 4'd4,
		OP_LDI   = 4'd5,
		OP_EQ    = 4'd6,
		OP_GT    = 4'd7,
		OP_GE    = 4'd8,
		OP_AND   = 4'd9,
		OP_OR    = 4'd10,
		OP_NOT   = 4'd11,
		OP_CJMP  = 4'd12,
		OP_JMP   = 4'd13,
		OP_MOV   = 4'd14
	} op_t;

endpackage

FILE: hdl/register_bytecode_executor.sv
// Register bytecode executor: register file, pc, sequencer and shared ALU/divider.
// Depends on rbe_pkg and register_bytecode_executor_assert.svh.
//
//  channel | dir | signals                     | payload
//  s       | in  | s_tvalid s_tready s_tdata   | one instruction + following code word
//  m       | out | m_tvalid m_tready m_tdata   | next pc, return value; m_tuser flags
//
// An instruction passes through accept with first read, second read, execute and
// write back. A div with a nonzero divisor adds divide steps before write back,
// made by the restoring divider that makes one quotient bit per cycle on the shared
// 33-bit adder. s_tready is high only while the sequencer is idle.
// The output register lets the next instruction start while a result waits;
// write back stalls if m is still full. Reset clears pc and register valid bits.
`timescale 1ns / 1ps

module register_bytecode_executor #(
	parameter int NUM_REGS = rbe_pkg::NUM_REGS_DEF,
	parameter int PC_WIDTH = rbe_pkg::PC_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// func[3:0], dest_reg[11:4], first_reg[19:12], second_reg[27:20], imm_word[59:28]
	input  logic [rbe_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// next_pc[15:0], return_value[47:16]
	output logic [rbe_pkg::M_TDATA_W-1:0]  m_tdata,
	// done_res[0], div_zero[1]
	output logic [rbe_pkg::M_TUSER_W-1:0]  m_tuser
);
	import rbe_pkg::*;

	localparam int IDX_W  = $clog2(NUM_REGS);
	localparam int IDXC_W = REG_IDX_W + 1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RDB  = 5'b00010,
		S_EXEC = 5'b00100,
		S_DIV  = 5'b01000,
		S_WB   = 5'b10000
	} state_t;

	state_t state_q;

	op_t                  op_q;
	logic [REG_IDX_W-1:0] dest_q;
	logic [REG_IDX_W-1:0] second_q;
	logic [WORD_W-1:0]    imm_q;
	logic [WORD_W-1:0]    a_q;
	logic [WORD_W-1:0]    res_q;
	logic                 wr_q;
	logic                 dz_q;
	logic [PC_WIDTH-1:0]  pc_q;

	logic [WORD_W-1:0]    r_q;
	logic [WORD_W-1:0]    q_q;
	logic [WORD_W-1:0]    mb_q;
	logic                 neg_q;
	logic [4:0]           div_cnt_q;

	logic [WORD_W-1:0]    mem [NUM_REGS];
	logic [NUM_REGS-1:0]  valid_q;
	logic [WORD_W-1:0]    rd_data_q;
	logic                 rd_ok_q;

	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;

	logic                 s_acc;
	logic                 out_load;
	logic [REG_IDX_W-1:0] rd_idx;
	logic                 rd_in_range;
	logic [IDX_W-1:0]     rd_addr;
	logic                 dest_in_range;
	logic                 wr_en;
	logic [WORD_W-1:0]    b_op;

	logic [WORD_W:0]      alu_x;
	logic [WORD_W:0]      alu_y;
	logic                 alu_sub;
	logic [WORD_W:0]      alu_sum;

	logic [WORD_W-1:0]    r_shift;
	logic [WORD_W-1:0]    q_next;
	logic [WORD_W-1:0]    r_next;
	logic [2*WORD_W-1:0]  prod;

	logic [PC_WIDTH-1:0]  npc;
	logic [WORD_W-1:0]    npc_ext;

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_load = (state_q == S_WB) && (!m_tvalid_q || m_tready);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// read port: first operand at acceptance, second in the next cycle (S_RDB)
	assign rd_idx      = (state_q == S_IDLE) ? s_tdata[19:12] : second_q;
	assign rd_in_range = ({1'b0, rd_idx} < IDXC_W'(NUM_REGS));
	assign rd_addr     = rd_in_range ? rd_idx[IDX_W-1:0] : '0;

	assign dest_in_range = ({1'b0, dest_q} < IDXC_W'(NUM_REGS));
	assign wr_en         = out_load && wr_q && dest_in_range;

	assign b_op = rd_ok_q ? rd_data_q : '0;

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (wr_en) begin
			mem[dest_q[IDX_W-1:0]] <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			rd_ok_q <= rd_in_range && valid_q[rd_addr];
			if (wr_en) begin
				valid_q[dest_q[IDX_W-1:0]] <= 1'b1;
			end
		end
	end

	// shared 33-bit adder: ALU ops in EXEC, trial subtract in DIV
	assign r_shift = {r_q[WORD_W-2:0], q_q[WORD_W-1]};

	always_comb begin
		if (state_q == S_DIV) begin
			alu_x   = {1'b0, r_shift};
			alu_y   = {1'b0, mb_q};
			alu_sub = 1'b1;
		end else begin
			alu_x   = {a_q[WORD_W-1], a_q};
			alu_y   = {b_op[WORD_W-1], b_op};
			alu_sub = (op_q != OP_ADD);
		end
		alu_sum = alu_x + (alu_sub ? ~alu_y : alu_y) + {{WORD_W{1'b0}}, alu_sub};
	end

	assign q_next = {q_q[WORD_W-2:0], ~alu_sum[WORD_W]};
	assign r_next = alu_sum[WORD_W] ? r_shift : alu_sum[WORD_W-1:0];
	assign prod   = a_q * b_op;

	always_comb begin
		unique case (op_q)
			OP_RET:  npc = pc_q;
			OP_LDI:  npc = pc_q + PC_WIDTH'(2);
			OP_CJMP: npc = a_q[0] ? imm_q[PC_WIDTH-1:0] : pc_q + PC_WIDTH'(2);
			OP_JMP:  npc = imm_q[PC_WIDTH-1:0];
			default: npc = pc_q + PC_WIDTH'(1);
		endcase
		npc_ext = WORD_W'(npc);
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q     <= op_t'(s_tdata[3:0]);
			dest_q   <= s_tdata[11:4];
			second_q <= s_tdata[27:20];
			imm_q    <= s_tdata[59:28];
		end
		if (state_q == S_RDB) begin
			a_q <= b_op;
		end
		if (state_q == S_EXEC) begin
			dz_q <= (op_q == OP_DIV) && (b_op == '0);
			// ret, cjmp, jmp and the unused code leave the register file alone
			wr_q <= (op_q != OP_RET) && (op_q != OP_CJMP) && (op_q != OP_JMP) &&
				(op_q <= OP_MOV);
			unique case (op_q)
				OP_ADD, OP_SUB: res_q <= alu_sum[WORD_W-1:0];
				OP_MUL:   res_q <= prod[WORD_W-1:0];
				OP_LDI:   res_q <= imm_q;
				OP_EQ:    res_q <= WORD_W'(a_q == b_op);
				OP_GT:    res_q <= WORD_W'(!alu_sum[WORD_W] && (a_q != b_op));
				OP_GE:    res_q <= WORD_W'(!alu_sum[WORD_W]);
				OP_AND:   res_q <= a_q & b_op;
				OP_OR:    res_q <= a_q | b_op;
				OP_NOT:   res_q <= ~a_q;
				OP_MOV:   res_q <= a_q;
				OP_DIV: begin
					res_q     <= '0;
					q_q       <= a_q[WORD_W-1] ? ('0 - a_q) : a_q;
					mb_q      <= b_op[WORD_W-1] ? ('0 - b_op) : b_op;
					neg_q     <= a_q[WORD_W-1] ^ b_op[WORD_W-1];
					r_q       <= '0;
					div_cnt_q <= 5'd31;
				end
				default: res_q <= '0;
			endcase
		end
		if (state_q == S_DIV) begin
			q_q       <= q_next;
			r_q       <= r_next;
			div_cnt_q <= div_cnt_q - 5'd1;
			if (div_cnt_q == 5'd0) begin
				res_q <= neg_q ? ('0 - q_next) : q_next;
			end
		end
		if (out_load) begin
			m_tdata_q <= {(op_q == OP_RET) ? a_q : {WORD_W{1'b0}}, npc_ext[NPC_W-1:0]};
			m_tuser_q <= {dz_q, (op_q == OP_RET)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pc_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				pc_q       <= npc;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (s_acc) state_q <= S_RDB;
				S_RDB:  state_q <= S_EXEC;
				S_EXEC: begin
					if (op_q == OP_DIV && b_op != '0) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_WB;
					end
				end
				S_DIV: if (div_cnt_q == 5'd0) state_q <= S_WB;
				S_WB:  if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`include "register_bytecode_executor_assert.svh"

	`RBE_ASSERT_NXT(a_div_end, (state_q == S_DIV) && (div_cnt_q == 5'd0), state_q == S_WB, "divider did not finish after 32 steps")
	`RBE_ASSERT_IMP(a_flags_excl, m_tvalid, !(m_tuser[0] && m_tuser[1]), "return and divide-by-zero both flagged")
	`RBE_ASSERT_NXT(a_ret_holds_pc, out_load && (op_q == OP_RET), pc_q == $past(pc_q), "return moved the pc")
	`RBE_ASSERT_IMP(a_no_idle_write, state_q != S_WB, !wr_en, "register file written outside write back")

endmodule

FILE: tb/sv/register_bytecode_executor_tb.sv
// Self-checking testbench for register_bytecode_executor: stream driver, result monitor,
// and an in-bench instruction predictor with its own register file and pc copy.
// Depends on rbe_pkg and the register_bytecode_executor RTL.
`timescale 1ns / 1ps

module register_bytecode_executor_tb;
	import rbe_pkg::*;

	typedef struct {
		op_t         func;
		logic [7:0]  dest;
		logic [7:0]  src_a;
		logic [7:0]  src_b;
		logic [31:0] imm;
		bit          drain_first; // sender waits for every result before offering this one
	} instr_t;

	typedef struct {
		logic [15:0] npc;
		logic        done;
		logic [31:0] retv;
		logic        dz;
	} retire_t;

	localparam int RANDOM_ITEMS = 400;
	localparam int HOLD_AT      = 120;
	localparam int HOLD_CYCLES  = 150;
	localparam int TAIL_NO_IDLE = 60;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [M_TUSER_W-1:0]  m_tuser;

	logic [31:0] shadow_regs [NUM_REGS_DEF];
	logic [15:0] shadow_pc;

	instr_t  program_q [$];
	retire_t predicted_retire_q [$];
	instr_t  offered;
	int      n_sent = 0;
	int      total_items = 0;
	int      n_errors = 0;
	int      src_gap = 0;
	int      sink_stall = 0;
	int      sink_hold = 0;
	bit      hold_done = 1'b0;
	logic    idle_on;

	register_bytecode_executor i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idling off in the tail and in every fourth stretch of 50 transactions
	assign idle_on = (n_sent + TAIL_NO_IDLE < total_items) && ((n_sent / 50) % 4 != 3);

	function automatic instr_t make_instr(op_t f, int d, int a, int b, logic [31:0] imm);
		instr_t it;
		it.func = f;
		it.dest = d[7:0];
		it.src_a = a[7:0];
		it.src_b = b[7:0];
		it.imm = imm;
		it.drain_first = 1'b0;
		return it;
	endfunction

	// signed divide, truncating toward zero; computed on magnitudes so that
	// the most negative value over -1 wraps instead of trapping
	function automatic logic [31:0] signed_quotient(logic [31:0] a, logic [31:0] b);
		logic [31:0] mag_a;
		logic [31:0] mag_b;
		logic [31:0] q;
		mag_a = a[31] ? (32'd0 - a) : a;
		mag_b = b[31] ? (32'd0 - b) : b;
		q = mag_a / mag_b;
		return (a[31] ^ b[31]) ? (32'd0 - q) : q;
	endfunction

	function automatic retire_t execute_instr(instr_t it);
		retire_t     r;
		logic [31:0] a;
		logic [31:0] b;
		logic [15:0] npc;
		bit          wr_en;
		logic [31:0] wr_val;
		a = shadow_regs[it.src_a];
		b = shadow_regs[it.src_b];
		npc = shadow_pc + 16'd1;
		wr_en = 1'b1;
		wr_val = '0;
		r.done = 1'b0;
		r.retv = '0;
		r.dz = 1'b0;
		case (it.func)
			OP_RET: begin
				wr_en = 1'b0;
				r.done = 1'b1;
				r.retv = a;
				npc = shadow_pc;
			end
			OP_ADD:   wr_val = a + b;
			OP_SUB:   wr_val = a - b;
			OP_MUL:   wr_val = a * b;
			OP_DIV: begin
				if (b == 32'd0) begin
					wr_val = '0;
					r.dz = 1'b1;
				end else begin
					wr_val = signed_quotient(a, b);
				end
			end
			OP_LDI: begin
				wr_val = it.imm;
				npc = shadow_pc + 16'd2;
			end
			OP_EQ:    wr_val = (a == b) ? 32'd1 : 32'd0;
			OP_GT:    wr_val = ($signed(a) > $signed(b)) ? 32'd1 : 32'd0;
			OP_GE:    wr_val = ($signed(a) >= $signed(b)) ? 32'd1 : 32'd0;
			OP_AND:   wr_val = a & b;
			OP_OR:    wr_val = a | b;
			OP_NOT:   wr_val = ~a;
			OP_CJMP: begin
				wr_en = 1'b0;
				npc = a[0] ? it.imm[15:0] : shadow_pc + 16'd2;
			end
			OP_JMP: begin
				wr_en = 1'b0;
				npc = it.imm[15:0];
			end
			OP_MOV:   wr_val = a;
			default:  wr_en = 1'b0;
		endcase
		if (wr_en)
			shadow_regs[it.dest] = wr_val;
		shadow_pc = npc;
		r.npc = npc;
		return r;
	endfunction

	// most indices from a small pool so that written registers get read back
	function automatic int pick_reg();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 70)
			return $urandom_range(0, 7);
		else if (sel < 85)
			return $urandom_range(248, 255);
		return $urandom_range(0, 255);
	endfunction

	function automatic instr_t random_instr();
		instr_t      it;
		logic [31:0] imm;
		op_t         f;
		imm = $urandom;
		if ($urandom_range(0, 99) < 20) begin
			f = OP_LDI;
			case ($urandom_range(0, 9))
				0: imm = 32'h0000_0000;
				1: imm = 32'h0000_0001;
				2: imm = 32'hFFFF_FFFF;
				3: imm = 32'h8000_0000;
				4: imm = 32'h7FFF_FFFF;
				default: ;
			endcase
		end else begin
			f = op_t'($urandom_range(0, 14));
		end
		it = make_instr(f, pick_reg(), pick_reg(), pick_reg(), imm);
		return it;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			src_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predicted_retire_q.push_back(execute_instr(offered));
				n_sent <= n_sent + 1;
			end
			if (s_tvalid && !s_tready) begin
				// transaction still pending, hold
			end else if (src_gap != 0) begin
				src_gap <= src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (s_tvalid && idle_on && $urandom_range(0, 5) == 0) begin
				src_gap <= $urandom_range(0, 13);
				s_tvalid <= 1'b0;
			end else if (program_q.size() != 0 &&
					(!program_q[0].drain_first || predicted_retire_q.size() == 0)) begin
				s_tvalid <= 1'b1;
				s_tdata <= {4'b0, program_q[0].imm, program_q[0].src_b, program_q[0].src_a,
					program_q[0].dest, program_q[0].func};
				offered <= program_q.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver ready: one long hold-off plus random stall bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_stall <= 0;
			sink_hold <= 0;
			hold_done <= 1'b0;
		end else if (sink_hold != 0) begin
			sink_hold <= sink_hold - 1;
			m_tready <= 1'b0;
		end else if (!hold_done && n_sent >= HOLD_AT) begin
			hold_done <= 1'b1;
			sink_hold <= HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else if (sink_stall != 0) begin
			sink_stall <= sink_stall - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			sink_stall <= $urandom_range(0, 13);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		retire_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (predicted_retire_q.size() == 0) begin
				$error("unexpected result: next_pc %0h tuser %0b", m_tdata[15:0], m_tuser);
				n_errors++;
			end else begin
				want = predicted_retire_q.pop_front();
				if (m_tdata[15:0] !== want.npc) begin
					$error("next_pc expected %0h got %0h", want.npc, m_tdata[15:0]);
					n_errors++;
				end
				if (m_tuser[0] !== want.done) begin
					$error("done_res expected %0b got %0b", want.done, m_tuser[0]);
					n_errors++;
				end
				if (m_tdata[47:16] !== want.retv) begin
					$error("return_value expected %0h got %0h", want.retv, m_tdata[47:16]);
					n_errors++;
				end
				if (m_tuser[1] !== want.dz) begin
					$error("div_zero expected %0b got %0b", want.dz, m_tuser[1]);
					n_errors++;
				end
			end
		end
	end

	initial begin
		instr_t it;
		int     n_directed;
		for (int i = 0; i < NUM_REGS_DEF; i++)
			shadow_regs[i] = '0;
		shadow_pc = '0;

		// directed: extremes, every opcode, divide corner cases, pc wrap
		program_q.push_back(make_instr(OP_RET,   0,   0,   0,   32'h0));
		program_q.push_back(make_instr(OP_LDI,   1,   0,   0,   32'h8000_0000));
		program_q.push_back(make_instr(OP_LDI,   2,   0,   0,   32'hFFFF_FFFF));
		program_q.push_back(make_instr(OP_LDI,   255, 0,   0,   32'h7FFF_FFFF));
		program_q.push_back(make_instr(OP_DIV,   3,   1,   2,   32'h0));
		program_q.push_back(make_instr(OP_DIV,   4,   1,   0,   32'h0));
		program_q.push_back(make_instr(OP_ADD,   5,   255, 255, 32'h0));
		program_q.push_back(make_instr(OP_SUB,   6,   1,   255, 32'h0));
		program_q.push_back(make_instr(OP_MUL,   7,   255, 255, 32'h0));
		program_q.push_back(make_instr(OP_EQ,    8,   1,   1,   32'h0));
		program_q.push_back(make_instr(OP_GT,    9,   255, 1,   32'h0));
		program_q.push_back(make_instr(OP_GE,    10,  1,   255, 32'h0));
		program_q.push_back(make_instr(OP_AND,   11,  2,   255, 32'h0));
		program_q.push_back(make_instr(OP_OR,    12,  1,   255, 32'h0));
		program_q.push_back(make_instr(OP_NOT,   13,  0,   0,   32'h0));
		program_q.push_back(make_instr(OP_MOV,   14,  255, 0,   32'h0));
		program_q.push_back(make_instr(OP_LDI,   15,  0,   0,   32'h0000_0007));
		program_q.push_back(make_instr(OP_DIV,   16,  1,   15,  32'h0));
		program_q.push_back(make_instr(OP_CJMP,  0,   8,   0,   32'hFFFF_FFFE));
		program_q.push_back(make_instr(OP_ADD,   17,  15,  15,  32'h0));
		program_q.push_back(make_instr(OP_LDI,   18,  0,   0,   32'hFFFF_FFF9));
		program_q.push_back(make_instr(OP_CJMP,  0,   0,   0,   32'h0000_1234));
		program_q.push_back(make_instr(OP_JMP,   0,   0,   0,   32'h1234_5678));
		program_q.push_back(make_instr(OP_RET,   0,   255, 0,   32'h0));
		program_q.push_back(make_instr(OP_RET,   0,   1,   0,   32'h0));
		n_directed = program_q.size();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			it = random_instr();
			if (i == 200)
				it.drain_first = 1'b1;
			program_q.push_back(it);
		end
		total_items = program_q.size();
		program_q[n_directed].drain_first = 1'b1;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (program_q.size() != 0 || s_tvalid || predicted_retire_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (predicted_retire_q.size() != 0) begin
			$error("%0d results never arrived", predicted_retire_q.size());
			n_errors++;
		end
		if (n_errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
